// ===== design/bfss_pkg.sv =====
// Shared types and constants of the burst frame slot selector.
package bfss_pkg;

  localparam int FOCUS_W    = 31;
  localparam int KEY_W      = 32;
  localparam int COUNT_W    = 20;
  localparam int SLOT_IDX_W = 7;
  localparam int CNT_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [KEY_W-1:0] PENDING_KEY = 32'h8000_0000;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_TICK  = 1'b1
  } bfss_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BEST_SHOTS_MODE = 2'd0,
    CFG_SLOT_COUNT      = 2'd1,
    CFG_MIN_FRAMES      = 2'd2,
    CFG_MAX_FRAMES      = 2'd3
  } bfss_cfg_idx_e;

  typedef struct packed {
    logic               command;
    logic               shutter_half_pressed;
    logic               settings_valid;
    logic [FOCUS_W-1:0] focus_measure;
  } bfss_req_t;

  typedef struct packed {
    logic                  slot_valid;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic                  capture_running;
    logic [COUNT_W-1:0]    frames_taken;
  } bfss_rsp_t;

  typedef enum logic {
    OP_CLEAR = 1'b0,
    OP_PICK  = 1'b1
  } bfss_op_e;

  typedef struct packed {
    logic               go;
    bfss_op_e           op;
    logic [FOCUS_W-1:0] focus;
    logic [CNT_W-1:0]   count;
  } bfss_scan_cmd_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [CNT_W-1:0] best;
  } bfss_scan_sts_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_WAIT_CLEAR,
    T_WAIT_PICK
  } bfss_top_state_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_FILE_RD,
    S_FILE_WR,
    S_SCAN,
    S_MARK
  } bfss_scan_state_e;

endpackage

// ===== design/bfss_focus_scan.sv =====
// Focus store memory with its clear sweep and least-focus search sequencer.
module bfss_focus_scan #(
  parameter int SLOTS = 128
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bfss_pkg::bfss_scan_cmd_t cmd_i,
  output bfss_pkg::bfss_scan_sts_t sts_o
);
  import bfss_pkg::*;

  localparam int IW = $clog2(SLOTS);

  logic [KEY_W-1:0] focus_mem_q [SLOTS];
  logic [KEY_W-1:0] rdata_q;

  bfss_scan_state_e state_q, state_d;
  logic [IW-1:0]      clr_ptr_q, clr_ptr_d;
  logic [CNT_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic               cmp_v_q, cmp_v_d;
  logic [CNT_W-1:0]   cmp_idx_q, cmp_idx_d;
  logic [KEY_W-1:0]   min_q, min_d;
  logic [CNT_W-1:0]   best_q, best_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [FOCUS_W-1:0] focus_q, focus_d;
  logic [IW-1:0]      last_q, last_d;
  logic [IW-1:0]      sbl_q, sbl_d;

  logic             mem_we, mem_re, done;
  logic [IW-1:0]    mem_waddr, mem_raddr;
  logic [KEY_W-1:0] mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      focus_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= focus_mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_ptr_q <= '0;
      rd_ptr_q  <= '0;
      cmp_v_q   <= 1'b0;
      last_q    <= '0;
      sbl_q     <= '0;
    end else begin
      state_q   <= state_d;
      clr_ptr_q <= clr_ptr_d;
      rd_ptr_q  <= rd_ptr_d;
      cmp_v_q   <= cmp_v_d;
      last_q    <= last_d;
      sbl_q     <= sbl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    min_q     <= min_d;
    best_q    <= best_d;
    count_q   <= count_d;
    focus_q   <= focus_d;
  end

  always_comb begin
    state_d   = state_q;
    clr_ptr_d = clr_ptr_q;
    rd_ptr_d  = rd_ptr_q;
    cmp_v_d   = 1'b0;
    cmp_idx_d = cmp_idx_q;
    min_d     = min_q;
    best_d    = best_q;
    count_d   = count_q;
    focus_d   = focus_q;
    last_d    = last_q;
    sbl_d     = sbl_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    done      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cmd_i.go) begin
          count_d   = cmd_i.count;
          focus_d   = cmd_i.focus;
          clr_ptr_d = '0;
          state_d   = (cmd_i.op == OP_CLEAR) ? S_CLEAR : S_FILE_RD;
        end
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_ptr_q;
        if (clr_ptr_q == IW'(SLOTS - 1)) begin
          done    = 1'b1;
          state_d = S_IDLE;
        end else begin
          clr_ptr_d = clr_ptr_q + 1'b1;
        end
      end
      S_FILE_RD: begin
        mem_re    = 1'b1;
        mem_raddr = sbl_q;
        state_d   = S_FILE_WR;
      end
      S_FILE_WR: begin
        if (rdata_q == PENDING_KEY) begin
          mem_we    = 1'b1;
          mem_waddr = sbl_q;
          mem_wdata = {1'b0, focus_q};
        end
        rd_ptr_d = '0;
        min_d    = PENDING_KEY;
        best_d   = '0;
        state_d  = S_SCAN;
      end
      S_SCAN: begin
        if (rd_ptr_q < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = IW'(rd_ptr_q);
          rd_ptr_d  = rd_ptr_q + 1'b1;
          cmp_v_d   = 1'b1;
          cmp_idx_d = rd_ptr_q;
        end
        if (cmp_v_q && (rdata_q < min_q)) begin
          min_d  = rdata_q;
          best_d = cmp_idx_q;
        end
        if (rd_ptr_q == count_q) begin
          state_d = S_MARK;
        end
      end
      S_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = IW'(best_q);
        mem_wdata = PENDING_KEY;
        sbl_d     = last_q;
        last_d    = IW'(best_q);
        done      = 1'b1;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign sts_o.busy = (state_q != S_IDLE);
  assign sts_o.done = done;
  assign sts_o.best = best_q;

  a_go_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.go |-> state_q == S_IDLE)
    else $error("Search engine commanded while busy.");

  a_best_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MARK |-> (best_q < count_q) || (count_q == '0))
    else $error("Chosen slot lies beyond the usable slots.");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> !done)
    else $error("Completion pulse lasted more than one cycle.");

endmodule

// ===== design/burst_frame_slot_selector.sv =====
// Top level of the burst frame slot selector: configuration, capture control and result.
// Results: a ring-order tick or a stopped or stopping tick gives its result in the cycle
// after the request; a best-shots tick runs the focus search (file read, file write, scan
// of the usable slots, mark), and a start waits for the one-entry-a-cycle store clear.
// Flow: one request at a time; for a start or best-shots tick, busy is high from acceptance
// until the result strobe; after reset the focus store clears under busy. Results cannot stall.
module burst_frame_slot_selector #(
  parameter int SLOTS = 128
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  bfss_pkg::bfss_req_t                 req_i,
  output logic                                done_o,
  output bfss_pkg::bfss_rsp_t                 rsp_o,
  input  logic                                cfg_we_i,
  input  logic [bfss_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bfss_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import bfss_pkg::*;

  localparam int UsableMax = (SLOTS > 255) ? 255 : SLOTS;

  logic               mode_q;
  logic [CNT_W-1:0]   slot_count_q;
  logic [CNT_W-1:0]   min_frames_q;
  logic [COUNT_W-1:0] max_frames_q;

  bfss_top_state_e    state_q, state_d;
  logic [COUNT_W-1:0] frame_count_q, frame_count_d;
  logic [CNT_W-1:0]   ring_q, ring_d;
  logic               running_q, running_d;
  logic               done_q, done_d;
  bfss_rsp_t          rsp_q, rsp_d;

  bfss_scan_cmd_t scan_cmd;
  bfss_scan_sts_t scan_sts;

  logic             accept;
  logic [CNT_W-1:0] usable;
  logic [CNT_W-1:0] ring_cur;
  logic [CNT_W:0]   ring_inc;
  logic             stop;

  bfss_focus_scan #(
    .SLOTS(SLOTS)
  ) u_scan (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (scan_cmd),
    .sts_o (scan_sts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 1'b0;
      slot_count_q <= '0;
      min_frames_q <= '0;
      max_frames_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BEST_SHOTS_MODE: mode_q       <= cfg_wdata_i[0];
        CFG_SLOT_COUNT:      slot_count_q <= cfg_wdata_i[CNT_W-1:0];
        CFG_MIN_FRAMES:      min_frames_q <= cfg_wdata_i[CNT_W-1:0];
        CFG_MAX_FRAMES:      max_frames_q <= cfg_wdata_i[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= T_IDLE;
      frame_count_q <= '0;
      ring_q        <= '0;
      running_q     <= 1'b0;
      done_q        <= 1'b0;
    end else begin
      state_q       <= state_d;
      frame_count_q <= frame_count_d;
      ring_q        <= ring_d;
      running_q     <= running_d;
      done_q        <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign busy   = (state_q != T_IDLE) || scan_sts.busy;
  assign accept = start && !busy;
  assign usable = (slot_count_q > CNT_W'(UsableMax)) ? CNT_W'(UsableMax) : slot_count_q;
  assign ring_cur = (ring_q >= usable) ? '0 : ring_q;
  assign ring_inc = {1'b0, ring_cur} + 1'b1;
  assign stop = (usable == '0) || !req_i.settings_valid ||
                ((frame_count_q >= COUNT_W'(min_frames_q)) && !req_i.shutter_half_pressed) ||
                (frame_count_q >= max_frames_q);

  always_comb begin
    state_d        = state_q;
    frame_count_d  = frame_count_q;
    ring_d         = ring_q;
    running_d      = running_q;
    done_d         = 1'b0;
    rsp_d          = rsp_q;
    scan_cmd.go    = 1'b0;
    scan_cmd.op    = OP_CLEAR;
    scan_cmd.focus = req_i.focus_measure;
    scan_cmd.count = usable;
    case (state_q)
      T_IDLE: begin
        if (accept) begin
          if (req_i.command == CMD_START) begin
            frame_count_d = '0;
            ring_d        = '0;
            running_d     = 1'b1;
            scan_cmd.go   = 1'b1;
            scan_cmd.op   = OP_CLEAR;
            state_d       = T_WAIT_CLEAR;
          end else if (!running_q) begin
            done_d = 1'b1;
            rsp_d  = '{slot_valid: 1'b0, slot_index: '0, capture_running: 1'b0,
                       frames_taken: frame_count_q};
          end else if (stop) begin
            running_d = 1'b0;
            done_d    = 1'b1;
            rsp_d     = '{slot_valid: 1'b0, slot_index: '0, capture_running: 1'b0,
                          frames_taken: frame_count_q};
          end else begin
            ring_d        = (ring_inc >= {1'b0, usable}) ? '0 : ring_inc[CNT_W-1:0];
            frame_count_d = frame_count_q + 1'b1;
            if (mode_q) begin
              scan_cmd.go = 1'b1;
              scan_cmd.op = OP_PICK;
              state_d     = T_WAIT_PICK;
            end else begin
              done_d = 1'b1;
              rsp_d  = '{slot_valid: 1'b1, slot_index: ring_cur[SLOT_IDX_W-1:0],
                         capture_running: 1'b1, frames_taken: frame_count_d};
            end
          end
        end
      end
      T_WAIT_CLEAR: begin
        if (scan_sts.done) begin
          done_d  = 1'b1;
          rsp_d   = '{slot_valid: 1'b0, slot_index: '0, capture_running: 1'b1,
                      frames_taken: frame_count_q};
          state_d = T_IDLE;
        end
      end
      T_WAIT_PICK: begin
        if (scan_sts.done) begin
          done_d  = 1'b1;
          rsp_d   = '{slot_valid: 1'b1, slot_index: scan_sts.best[SLOT_IDX_W-1:0],
                      capture_running: 1'b1, frames_taken: frame_count_q};
          state_d = T_IDLE;
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_stopped_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.command == CMD_TICK) && !running_q |=> done_o && !rsp_o.slot_valid)
    else $error("A tick while stopped did not give an empty result next cycle.");

  a_slot_implies_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.slot_valid |-> rsp_o.capture_running)
    else $error("A slot was assigned while capture is not running.");

  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.slot_valid |-> CNT_W'(rsp_o.slot_index) < usable)
    else $error("Assigned slot lies beyond the usable slots.");

  a_no_accept_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != T_IDLE |-> !accept)
    else $error("A request was accepted while a search or clear is outstanding.");

endmodule
